@@ sv/absm_pkg.sv @@
// ----------------------------------------------------------------------------
// absm_pkg
// shared types, codes and widths of the a/b boot slot manager
// ----------------------------------------------------------------------------
`default_nettype none

package absm_pkg;

    localparam int VERSION_BYTES_DEF = 8;
    localparam int TAG_W             = 64;
    localparam int SUM_W             = 32;
    localparam int CNT_W             = 16;
    localparam int STATE_W           = 3;
    localparam int OP_W              = 3;

    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 152;
    localparam int M_USER_W = 1;

    localparam logic [OP_W-1:0] OP_QUERY_SLOT   = 3'd0;
    localparam logic [OP_W-1:0] OP_QUERY_ACTIVE = 3'd1;
    localparam logic [OP_W-1:0] OP_STAGE        = 3'd2;
    localparam logic [OP_W-1:0] OP_ACTIVATE     = 3'd3;
    localparam logic [OP_W-1:0] OP_CONFIRM      = 3'd4;
    localparam logic [OP_W-1:0] OP_ROLLBACK     = 3'd5;

    localparam logic [STATE_W-1:0] SLOT_EMPTY    = 3'd0;
    localparam logic [STATE_W-1:0] SLOT_VALID    = 3'd1;
    localparam logic [STATE_W-1:0] SLOT_ACTIVE   = 3'd2;
    localparam logic [STATE_W-1:0] SLOT_ROLLBACK = 3'd3;
    localparam logic [STATE_W-1:0] SLOT_FAILED   = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic exec;
    } absm_cmd_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ sv/ab_boot_slot_manager.sv @@
// ----------------------------------------------------------------------------
// ab_boot_slot_manager
// two-slot boot manager: stage, activate, confirm, rollback and query
// ----------------------------------------------------------------------------
// usage
//   one request on the s_axis channel gives exactly one result on m_axis
//   request tuser carries the operation and slot index, tdata the version
//   tag and checksum used by stage
//   result tuser is the status, tdata the active slot, pending flag and the
//   full record of the reported slot, all as they stand after the request
//   latency: the result is valid the cycle after the request is accepted
//   throughput: one request per cycle while results are taken at once; the
//   single result register sets this, a new request enters in the cycle its
//   predecessor's result is taken
//   when the receiver stalls, the result holds and s_axis_tready stays low
//   reset clears both slots to empty with zero records, active slot a,
//   nothing pending and no result valid
// ----------------------------------------------------------------------------
`default_nettype none

module ab_boot_slot_manager
    import absm_pkg::*;
#(
    parameter int VERSION_BYTES = VERSION_BYTES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // version_tag[63:0], checksum_in[95:64]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // operation[2:0], slot_index[3]
    input  wire logic [S_USER_W-1:0] s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // active_now[0], pending_now[1], reported_state[4:2],
    // reported_version[68:5], reported_checksum[100:69], reported_health[101],
    // reported_boots[117:102], reported_successes[133:118],
    // reported_failures[149:134], zero pad[151:150]
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    // status[0]
    output logic [M_USER_W-1:0]      m_axis_tuser
);

    absm_cmd_t cmd;

    absm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    absm_dpath #(
        .VERSION_BYTES (VERSION_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (s_axis_tuser[2:0]),
        .slot_index  (s_axis_tuser[3]),
        .version_tag (s_axis_tdata[63:0]),
        .checksum_in (s_axis_tdata[95:64]),
        .result_data (m_axis_tdata),
        .result_user (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ sv/absm_ctrl.sv @@
// ----------------------------------------------------------------------------
// absm_ctrl
// request handshake control: accepts a request, holds the result until taken
// ----------------------------------------------------------------------------
`default_nettype none

module absm_ctrl
    import absm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_axis_tvalid,
    output logic           s_axis_tready,
    output logic           m_axis_tvalid,
    input  wire logic      m_axis_tready,
    output absm_cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FULL = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_axis_tready = (state_reg == S_IDLE) || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == S_FULL);
    assign cmd.exec      = accept;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = accept ? S_FULL : S_IDLE;
            end
            S_FULL:
            begin
                if (accept)
                begin
                    state_next = S_FULL;
                end
                else if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FULL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/absm_dpath.sv @@
// ----------------------------------------------------------------------------
// absm_dpath
// slot records, command execution and the registered result
// ----------------------------------------------------------------------------
`default_nettype none

module absm_dpath
    import absm_pkg::*;
#(
    parameter int VERSION_BYTES = VERSION_BYTES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire absm_cmd_t             cmd,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic                  slot_index,
    input  wire logic [TAG_W-1:0]      version_tag,
    input  wire logic [SUM_W-1:0]      checksum_in,
    output logic [M_DATA_W-1:0]        result_data,
    output logic [M_USER_W-1:0]        result_user
);

    localparam int VW = VERSION_BYTES * 8;

    logic [STATE_W-1:0] state_reg   [2];
    logic [VW-1:0]      version_reg [2];
    logic [SUM_W-1:0]   sum_reg     [2];
    logic               health_reg  [2];
    logic [CNT_W-1:0]   boots_reg   [2];
    logic [CNT_W-1:0]   succ_reg    [2];
    logic [CNT_W-1:0]   fail_reg    [2];
    logic               active_reg;
    logic               pending_reg;

    logic [STATE_W-1:0] state_next   [2];
    logic [VW-1:0]      version_next [2];
    logic [SUM_W-1:0]   sum_next     [2];
    logic               health_next  [2];
    logic [CNT_W-1:0]   boots_next   [2];
    logic [CNT_W-1:0]   succ_next    [2];
    logic [CNT_W-1:0]   fail_next    [2];
    logic               active_next;
    logic               pending_next;

    logic [M_DATA_W-1:0] data_reg;
    logic [M_USER_W-1:0] user_reg;

    logic [VW-1:0] trimmed;
    logic          act;
    logic          oth;
    logic          act_ok;
    logic          rb_ok;
    logic          status;
    logic          rep;

    // keep bytes up to the first zero byte
    always_comb
    begin
        logic keep;
        keep = 1'b1;
        for (int i = 0; i < VERSION_BYTES; i++)
        begin
            if (version_tag[8*i +: 8] == 8'd0)
            begin
                keep = 1'b0;
            end
            trimmed[8*i +: 8] = keep ? version_tag[8*i +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        act    = active_reg;
        oth    = ~active_reg;
        act_ok = (state_reg[slot_index] == SLOT_VALID)
              || (state_reg[slot_index] == SLOT_ACTIVE);
        rb_ok  = (state_reg[oth] == SLOT_ROLLBACK) || (state_reg[oth] == SLOT_VALID);

        for (int i = 0; i < 2; i++)
        begin
            state_next[i]   = state_reg[i];
            version_next[i] = version_reg[i];
            sum_next[i]     = sum_reg[i];
            health_next[i]  = health_reg[i];
            boots_next[i]   = boots_reg[i];
            succ_next[i]    = succ_reg[i];
            fail_next[i]    = fail_reg[i];
        end
        active_next  = active_reg;
        pending_next = pending_reg;
        status       = STATUS_OK;

        unique case (operation)
            OP_QUERY_SLOT, OP_QUERY_ACTIVE:
            begin
                status = STATUS_OK;
            end
            OP_STAGE:
            begin
                version_next[slot_index] = trimmed;
                sum_next[slot_index]     = checksum_in;
                state_next[slot_index]   = SLOT_VALID;
                health_next[slot_index]  = 1'b0;
                boots_next[slot_index]   = '0;
                succ_next[slot_index]    = '0;
                fail_next[slot_index]    = '0;
            end
            OP_ACTIVATE:
            begin
                if (!act_ok)
                begin
                    status = STATUS_REFUSED;
                end
                else
                begin
                    if (act != slot_index)
                    begin
                        state_next[act] = SLOT_ROLLBACK;
                    end
                    state_next[slot_index] = SLOT_ACTIVE;
                    boots_next[slot_index] = sat_inc(boots_reg[slot_index]);
                    active_next            = slot_index;
                    pending_next           = 1'b1;
                end
            end
            OP_CONFIRM:
            begin
                health_next[act] = 1'b1;
                succ_next[act]   = sat_inc(succ_reg[act]);
                pending_next     = 1'b0;
            end
            OP_ROLLBACK:
            begin
                if (rb_ok)
                begin
                    state_next[act] = SLOT_FAILED;
                    fail_next[act]  = sat_inc(fail_reg[act]);
                    state_next[oth] = SLOT_ACTIVE;
                    active_next     = oth;
                    pending_next    = 1'b0;
                end
                else
                begin
                    status = STATUS_REFUSED;
                end
            end
            default:
            begin
                status = STATUS_REFUSED;
            end
        endcase

        rep = ((operation == OP_QUERY_SLOT) || (operation == OP_STAGE)
            || (operation == OP_ACTIVATE)) ? slot_index : active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                state_reg[i]   <= SLOT_EMPTY;
                version_reg[i] <= '0;
                sum_reg[i]     <= '0;
                health_reg[i]  <= 1'b0;
                boots_reg[i]   <= '0;
                succ_reg[i]    <= '0;
                fail_reg[i]    <= '0;
            end
            active_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            for (int i = 0; i < 2; i++)
            begin
                state_reg[i]   <= state_next[i];
                version_reg[i] <= version_next[i];
                sum_reg[i]     <= sum_next[i];
                health_reg[i]  <= health_next[i];
                boots_reg[i]   <= boots_next[i];
                succ_reg[i]    <= succ_next[i];
                fail_reg[i]    <= fail_next[i];
            end
            active_reg  <= active_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            data_reg <= {2'b00, fail_next[rep], succ_next[rep], boots_next[rep],
                         health_next[rep], sum_next[rep], TAG_W'(version_next[rep]),
                         state_next[rep], pending_next, active_next};
            user_reg <= status;
        end
    end

    assign result_data = data_reg;
    assign result_user = user_reg;

endmodule

`default_nettype wire

@@ sv/absm_checker.sv @@
// ----------------------------------------------------------------------------
// absm_checker
// port-level checks of the boot slot manager, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module absm_checker
    import absm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [S_USER_W-1:0] s_axis_tuser,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic [M_USER_W-1:0] m_axis_tuser
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted request");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while result stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[2:0] == OP_QUERY_SLOT)
        |=> m_axis_tuser[0] == STATUS_OK)
        else $error("query refused");

    a_unknown_refused: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && ((s_axis_tuser[2:0] == 3'd6) || (s_axis_tuser[2:0] == 3'd7))
        |=> m_axis_tuser[0] == STATUS_REFUSED)
        else $error("unknown operation not refused");

endmodule

bind ab_boot_slot_manager absm_checker u_absm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ dv/ab_boot_slot_manager_test.sv @@
// ----------------------------------------------------------------------------
// ab_boot_slot_manager_test
// self-checking bench for the a/b boot slot manager: a directed command table,
// a short back-to-back activate and confirm run and random command traffic,
// each result checked field by field against a slot record model kept here
// ----------------------------------------------------------------------------
module ab_boot_slot_manager_test
    import absm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam logic            SLOT_A      = 1'b0;
    localparam logic            SLOT_B      = 1'b1;

    localparam int DIRECTED_COUNT   = 25;
    localparam int FULL_RATE_PAIRS  = 20;
    localparam int RANDOM_ITEMS     = 885;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct packed {
        logic               status;
        logic               active_now;
        logic               pending;
        logic [STATE_W-1:0] state;
        logic [TAG_W-1:0]   version;
        logic [SUM_W-1:0]   checksum;
        logic               health;
        logic [CNT_W-1:0]   boots;
        logic [CNT_W-1:0]   successes;
        logic [CNT_W-1:0]   failures;
    } slot_report_t;

    typedef struct packed {
        logic               fixed;
        logic               status;
        logic               active_now;
        logic               pending;
        logic [STATE_W-1:0] state;
    } outcome_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             slot;
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] sum;
        outcome_t         outcome;
    } command_row_t;

    localparam outcome_t UNFIXED = '0;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [S_USER_W-1:0] s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;

    logic [STATE_W-1:0] rec_state     [2];
    logic [TAG_W-1:0]   rec_version   [2];
    logic [SUM_W-1:0]   rec_checksum  [2];
    logic               rec_health    [2];
    logic [CNT_W-1:0]   rec_boots     [2];
    logic [CNT_W-1:0]   rec_successes [2];
    logic [CNT_W-1:0]   rec_failures  [2];
    logic               cur_active;
    logic               boot_pending;

    slot_report_t pending_reports[$];
    outcome_t     request_outcomes[$];
    int unsigned  error_count;
    bit           full_rate;
    bit           random_phase;
    int           burst_left;

    command_row_t command_table [DIRECTED_COUNT] = '{
        '{OP_QUERY_SLOT,   SLOT_A, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_QUERY_SLOT,   SLOT_B, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_QUERY_ACTIVE, SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_ACTIVATE,     SLOT_A, 64'h0, 32'h0,
          '{1'b1, STATUS_REFUSED, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_ROLLBACK,     SLOT_A, 64'h0, 32'h0,
          '{1'b1, STATUS_REFUSED, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_UNUSED_6,     SLOT_A, 64'h0, 32'h0,
          '{1'b1, STATUS_REFUSED, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_UNUSED_7,     SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_REFUSED, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_CONFIRM,      SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_EMPTY}},
        '{OP_STAGE,        SLOT_A, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_VALID}},
        '{OP_STAGE,        SLOT_B, 64'h1122_3344_0055_6677, 32'h0, UNFIXED},
        '{OP_STAGE,        SLOT_B, 64'h0, 32'h8000_0001, UNFIXED},
        '{OP_STAGE,        SLOT_B, 64'hFF00_0000_0000_00FF, 32'h1234_5678, UNFIXED},
        '{OP_STAGE,        SLOT_B, 64'h8001_0203_0405_0607, 32'hDEAD_BEEF, UNFIXED},
        '{OP_ACTIVATE,     SLOT_A, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b1, SLOT_ACTIVE}},
        '{OP_CONFIRM,      SLOT_A, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_ACTIVE}},
        '{OP_ACTIVATE,     SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_B, 1'b1, SLOT_ACTIVE}},
        '{OP_ACTIVATE,     SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_B, 1'b1, SLOT_ACTIVE}},
        '{OP_ROLLBACK,     SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_ACTIVE}},
        '{OP_ROLLBACK,     SLOT_A, 64'h0, 32'h0,
          '{1'b1, STATUS_REFUSED, SLOT_A, 1'b0, SLOT_ACTIVE}},
        '{OP_QUERY_SLOT,   SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_FAILED}},
        '{OP_ACTIVATE,     SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_REFUSED, SLOT_A, 1'b0, SLOT_FAILED}},
        '{OP_STAGE,        SLOT_A, 64'h0000_0000_0000_0031, 32'h0000_FFFF,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_VALID}},
        '{OP_QUERY_ACTIVE, SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_A, 1'b0, SLOT_VALID}},
        '{OP_STAGE,        SLOT_B, 64'h0102_0304_0506_0708, 32'hA5A5_5A5A, UNFIXED},
        '{OP_ACTIVATE,     SLOT_B, 64'h0, 32'h0,
          '{1'b1, STATUS_OK, SLOT_B, 1'b1, SLOT_ACTIVE}}
    };

    ab_boot_slot_manager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic slot_report_t apply_command(input logic [OP_W-1:0] op,
                                                   input logic slot,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic [SUM_W-1:0] sum);
        slot_report_t     r;
        logic             act;
        logic             other;
        logic             shown;
        logic [TAG_W-1:0] kept;
        bit               ended;
        act = cur_active;
        other = ~cur_active;
        r = '0;
        r.status = STATUS_OK;
        case (op)
            OP_QUERY_SLOT, OP_QUERY_ACTIVE:
            begin
            end
            OP_STAGE:
            begin
                kept = '0;
                ended = 1'b0;
                // a zero byte ends the version string
                for (int b = 0; b < VERSION_BYTES_DEF; b++)
                begin
                    if (tag[8*b +: 8] == 8'h00)
                        ended = 1'b1;
                    if (!ended)
                        kept[8*b +: 8] = tag[8*b +: 8];
                end
                rec_version[slot] = kept;
                rec_checksum[slot] = sum;
                rec_state[slot] = SLOT_VALID;
                rec_health[slot] = 1'b0;
                rec_boots[slot] = '0;
                rec_successes[slot] = '0;
                rec_failures[slot] = '0;
            end
            OP_ACTIVATE:
            begin
                if (rec_state[slot] != SLOT_VALID && rec_state[slot] != SLOT_ACTIVE)
                    r.status = STATUS_REFUSED;
                else
                begin
                    if (act != slot)
                        rec_state[act] = SLOT_ROLLBACK;
                    rec_state[slot] = SLOT_ACTIVE;
                    if (rec_boots[slot] != '1)
                        rec_boots[slot] += CNT_W'(1);
                    cur_active = slot;
                    boot_pending = 1'b1;
                end
            end
            OP_CONFIRM:
            begin
                rec_health[act] = 1'b1;
                if (rec_successes[act] != '1)
                    rec_successes[act] += CNT_W'(1);
                boot_pending = 1'b0;
            end
            OP_ROLLBACK:
            begin
                if (rec_state[other] == SLOT_ROLLBACK || rec_state[other] == SLOT_VALID)
                begin
                    rec_state[act] = SLOT_FAILED;
                    if (rec_failures[act] != '1)
                        rec_failures[act] += CNT_W'(1);
                    rec_state[other] = SLOT_ACTIVE;
                    cur_active = other;
                    boot_pending = 1'b0;
                end
                else
                    r.status = STATUS_REFUSED;
            end
            default:
                r.status = STATUS_REFUSED;
        endcase
        shown = (op == OP_QUERY_SLOT || op == OP_STAGE || op == OP_ACTIVATE) ?
                slot : cur_active;
        r.active_now = cur_active;
        r.pending = boot_pending;
        r.state = rec_state[shown];
        r.version = rec_version[shown];
        r.checksum = rec_checksum[shown];
        r.health = rec_health[shown];
        r.boots = rec_boots[shown];
        r.successes = rec_successes[shown];
        r.failures = rec_failures[shown];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        slot_report_t got;
        slot_report_t want;
        outcome_t     outcome;
        if (rst_n === 1'b1)
        begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            begin
                got.status = m_axis_tuser[0];
                got.active_now = m_axis_tdata[0];
                got.pending = m_axis_tdata[1];
                got.state = m_axis_tdata[4:2];
                got.version = m_axis_tdata[68:5];
                got.checksum = m_axis_tdata[100:69];
                got.health = m_axis_tdata[101];
                got.boots = m_axis_tdata[117:102];
                got.successes = m_axis_tdata[133:118];
                got.failures = m_axis_tdata[149:134];
                if (pending_reports.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with no request outstanding, actual %0h",
                             $time, got);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("active_now", 64'(want.active_now), 64'(got.active_now));
                    check_field("pending_now", 64'(want.pending), 64'(got.pending));
                    check_field("reported_state", 64'(want.state), 64'(got.state));
                    check_field("reported_version", want.version, got.version);
                    check_field("reported_checksum", 64'(want.checksum),
                                64'(got.checksum));
                    check_field("reported_health", 64'(want.health), 64'(got.health));
                    check_field("reported_boots", 64'(want.boots), 64'(got.boots));
                    check_field("reported_successes", 64'(want.successes),
                                64'(got.successes));
                    check_field("reported_failures", 64'(want.failures),
                                64'(got.failures));
                end
            end
            if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            begin
                outcome = request_outcomes.pop_front();
                want = apply_command(s_axis_tuser[2:0], s_axis_tuser[3],
                                     s_axis_tdata[63:0], s_axis_tdata[95:64]);
                // table rows other than the unfixed ones carry their outcome typed in
                if (outcome.fixed)
                begin
                    want.status = outcome.status;
                    want.active_now = outcome.active_now;
                    want.pending = outcome.pending;
                    want.state = outcome.state;
                end
                pending_reports.push_back(want);
            end
        end
    end

    initial
    begin : receiver
        int seg_len;
        int mode;
        int period;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (full_rate)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else if (random_phase && !hold_done)
            begin
                // long back-pressure so the request side fills and stalls
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                seg_len = $urandom_range(10, 120);
                mode = $urandom_range(0, 3);
                period = $urandom_range(2, 7);
                for (int i = 0; i < seg_len; i++)
                begin
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= 1'($urandom_range(0, 1));
                        2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                        default: m_axis_tready <= ((i % period) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic issue_command(input logic [OP_W-1:0] op, input logic slot,
                                 input logic [TAG_W-1:0] tag,
                                 input logic [SUM_W-1:0] sum, input outcome_t outcome);
        int gap;
        request_outcomes.push_back(outcome);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {slot, op};
        s_axis_tdata <= {sum, tag};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        if (!full_rate)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = $urandom_range(1, 8);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 1) ? $urandom_range(0, 5) :
                             $urandom_range(10, 40);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] tag;
        int               pick;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        error_count = 0;
        full_rate = 1'b0;
        random_phase = 1'b0;
        burst_left = 0;
        for (int s = 0; s < 2; s++)
        begin
            rec_state[s] = SLOT_EMPTY;
            rec_version[s] = '0;
            rec_checksum[s] = '0;
            rec_health[s] = 1'b0;
            rec_boots[s] = '0;
            rec_successes[s] = '0;
            rec_failures[s] = '0;
        end
        cur_active = SLOT_A;
        boot_pending = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (command_table[i])
            issue_command(command_table[i].op, command_table[i].slot, command_table[i].tag,
                          command_table[i].sum, command_table[i].outcome);

        // slot b is active: activate and confirm back to back at full rate
        full_rate = 1'b1;
        for (int n = 0; n < FULL_RATE_PAIRS; n++)
        begin
            issue_command(OP_ACTIVATE, SLOT_B, {$urandom, $urandom}, $urandom, UNFIXED);
            issue_command(OP_CONFIRM, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                          $urandom, UNFIXED);
        end
        issue_command(OP_QUERY_SLOT, SLOT_B, '0, '0, UNFIXED);
        full_rate = 1'b0;

        random_phase = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                op = OP_QUERY_SLOT;
            else if (pick < 20)
                op = OP_QUERY_ACTIVE;
            else if (pick < 40)
                op = OP_STAGE;
            else if (pick < 62)
                op = OP_ACTIVATE;
            else if (pick < 78)
                op = OP_CONFIRM;
            else if (pick < 94)
                op = OP_ROLLBACK;
            else
                op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
            tag = {$urandom, $urandom};
            for (int b = 0; b < 8; b++)
                if ($urandom_range(0, 9) == 0)
                    tag[8*b +: 8] = 8'h00;
            issue_command(op, 1'($urandom_range(0, 1)), tag, $urandom, UNFIXED);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0 || request_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
